// ===== rtl/onb_pkg.sv =====
// Shared types and constants for the orthonormal basis builder.
`timescale 1ns / 1ps
package onb_pkg;

  localparam int FRAC_BITS_DEF = 30;
  localparam int THRESH_W      = 31;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd107374;

  // Normalizer geometry: magnitudes are scaled so the largest one has its
  // top bit at NORM_MSB, which gives MAG_W bit mantissas.
  localparam int NORM_MSB   = 30;
  localparam int MAG_W      = 31;
  localparam int SQRT_STEPS = 32;
  localparam int NORM_PRE   = 5;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

  typedef enum logic [3:0] {
    MODE_U  = 4'd0,
    MODE_V  = 4'd1,
    MODE_W  = 4'd2,
    MODE_UV = 4'd3,
    MODE_VU = 4'd4,
    MODE_UW = 4'd5,
    MODE_WU = 4'd6,
    MODE_VW = 4'd7,
    MODE_WV = 4'd8
  } mode_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
  } request_t;

  typedef struct packed {
    logic signed [31:0] basis_u_x;
    logic signed [31:0] basis_u_y;
    logic signed [31:0] basis_u_z;
    logic signed [31:0] basis_v_x;
    logic signed [31:0] basis_v_y;
    logic signed [31:0] basis_v_z;
    logic signed [31:0] basis_w_x;
    logic signed [31:0] basis_w_y;
    logic signed [31:0] basis_w_z;
    logic               degenerate;
  } result_t;

endpackage

// ===== rtl/onb_norm.sv =====
// Pipelined vector normalizer: scale, square sum, square root, divide.
`timescale 1ns / 1ps
module onb_norm import onb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  vec64_t vec,
  output logic   out_valid,
  output vec32_t unit,
  output logic   zero
);

  localparam int DIV_STEPS = MAG_W + FRAC_BITS;

  function automatic logic [5:0] msb_pos(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  // stage a: magnitudes
  logic                 va;
  logic [2:0][63:0]     mag_a;
  logic [2:0]           neg_a;
  // stage b: leading one of the largest magnitude
  logic                 vb;
  logic [2:0][63:0]     mag_b;
  logic [2:0]           neg_b;
  logic [5:0]           pos_b;
  logic                 zero_b;
  // stage c: scaled magnitudes
  logic                 vc;
  logic [2:0][MAG_W-1:0] nm_c;
  logic [2:0]           neg_c;
  logic                 zero_c;
  // stage d: squares
  logic                 vd;
  logic [2:0][61:0]     sq_d;
  logic [2:0][MAG_W-1:0] nm_d;
  logic [2:0]           neg_d;
  logic                 zero_d;

  // square root stages
  logic                  sq_val  [0:SQRT_STEPS];
  logic [63:0]           sq_len  [0:SQRT_STEPS];
  logic [32:0]           sq_rem  [0:SQRT_STEPS];
  logic [31:0]           sq_root [0:SQRT_STEPS];
  logic [2:0][MAG_W-1:0] sq_nm   [0:SQRT_STEPS];
  logic [2:0]            sq_neg  [0:SQRT_STEPS];
  logic                  sq_zero [0:SQRT_STEPS];

  // divider stages
  logic                    dv_val  [0:DIV_STEPS-1];
  logic [31:0]             dv_s    [0:DIV_STEPS-1];
  logic [2:0][31:0]        dv_rem  [0:DIV_STEPS-1];
  logic [2:0][MAG_W-1:0]   dv_dvd  [0:DIV_STEPS-1];
  logic [2:0][DIV_STEPS-1:0] dv_q  [0:DIV_STEPS-1];
  logic [2:0]              dv_neg  [0:DIV_STEPS-1];
  logic                    dv_zero [0:DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      sq_val[0] <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      sq_val[0] <= vd;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_a[i] <= vec[i][63] ? 64'd0 - vec[i] : vec[i];
      neg_a[i] <= vec[i][63];
    end
    mag_b  <= mag_a;
    neg_b  <= neg_a;
    pos_b  <= msb_pos(mag_a[0] | mag_a[1] | mag_a[2]);
    zero_b <= (mag_a[0] | mag_a[1] | mag_a[2]) == 64'd0;
    for (int i = 0; i < 3; i++) begin
      if (pos_b >= 6'(NORM_MSB)) begin
        nm_c[i] <= MAG_W'(mag_b[i] >> (pos_b - 6'(NORM_MSB)));
      end else begin
        nm_c[i] <= MAG_W'(mag_b[i] << (6'(NORM_MSB) - pos_b));
      end
    end
    neg_c  <= neg_b;
    zero_c <= zero_b;
    for (int i = 0; i < 3; i++) begin
      sq_d[i] <= 62'(nm_c[i]) * 62'(nm_c[i]);
    end
    nm_d   <= nm_c;
    neg_d  <= neg_c;
    zero_d <= zero_c;
    sq_len[0]  <= 64'(sq_d[0]) + 64'(sq_d[1]) + 64'(sq_d[2]);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_nm[0]   <= nm_d;
    sq_neg[0]  <= neg_d;
    sq_zero[0] <= zero_d;
  end

  // one root bit per stage, two radicand bits brought down
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        take;
    assign rem2  = {sq_rem[k], sq_len[k][63:62]};
    assign trial = {1'b0, sq_root[k], 2'b01};
    assign take  = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_val[k+1] <= 1'b0;
      end else begin
        sq_val[k+1] <= sq_val[k];
      end
    end
    always_ff @(posedge clk) begin
      sq_rem[k+1]  <= take ? 33'(rem2 - trial) : rem2[32:0];
      sq_root[k+1] <= {sq_root[k][30:0], take};
      sq_len[k+1]  <= {sq_len[k][61:0], 2'b00};
      sq_nm[k+1]   <= sq_nm[k];
      sq_neg[k+1]  <= sq_neg[k];
      sq_zero[k+1] <= sq_zero[k];
    end
  end

  // one quotient bit per stage, three lanes share the root
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic                      src_val;
    logic [31:0]               src_s;
    logic [2:0][31:0]          src_rem;
    logic [2:0][MAG_W-1:0]     src_dvd;
    logic [2:0][DIV_STEPS-1:0] src_q;
    logic [2:0]                src_neg;
    logic                      src_zero;
    if (k == 0) begin : g_first
      assign src_val  = sq_val[SQRT_STEPS];
      assign src_s    = sq_root[SQRT_STEPS];
      assign src_rem  = '0;
      assign src_dvd  = sq_nm[SQRT_STEPS];
      assign src_q    = '0;
      assign src_neg  = sq_neg[SQRT_STEPS];
      assign src_zero = sq_zero[SQRT_STEPS];
    end else begin : g_next
      assign src_val  = dv_val[k-1];
      assign src_s    = dv_s[k-1];
      assign src_rem  = dv_rem[k-1];
      assign src_dvd  = dv_dvd[k-1];
      assign src_q    = dv_q[k-1];
      assign src_neg  = dv_neg[k-1];
      assign src_zero = dv_zero[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_val[k] <= 1'b0;
      end else begin
        dv_val[k] <= src_val;
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [32:0] r2;
      logic        take;
      assign r2   = {src_rem[i], src_dvd[i][MAG_W-1]};
      assign take = r2 >= {1'b0, src_s};
      always_ff @(posedge clk) begin
        dv_rem[k][i] <= take ? 32'(r2 - {1'b0, src_s}) : r2[31:0];
        dv_q[k][i]   <= {src_q[i][DIV_STEPS-2:0], take};
        dv_dvd[k][i] <= {src_dvd[i][MAG_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      dv_s[k]    <= src_s;
      dv_neg[k]  <= src_neg;
      dv_zero[k] <= src_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_val[DIV_STEPS-1];
    end
  end

  // apply sign and saturate to 32 bits
  always_ff @(posedge clk) begin
    zero <= dv_zero[DIV_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[DIV_STEPS-1]) begin
        unit[i] <= '0;
      end else if (!dv_neg[DIV_STEPS-1][i]) begin
        unit[i] <= (dv_q[DIV_STEPS-1][i] > DIV_STEPS'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                   : dv_q[DIV_STEPS-1][i][31:0];
      end else begin
        unit[i] <= (dv_q[DIV_STEPS-1][i] >= DIV_STEPS'(33'h0_8000_0000)) ? 32'h8000_0000
                   : 32'd0 - dv_q[DIV_STEPS-1][i][31:0];
      end
    end
  end

endmodule

// ===== rtl/orthonormal_basis_builder.sv =====
// Top level of the orthonormal basis builder.
`timescale 1ns / 1ps
// Builds an orthonormal frame u, v, w (Q2.30 by default) from one axis or an
// ordered pair of axes, selected by request.cmd.
// Input: drive request and raise start; the item is taken at that edge.
// busy is always low, so one item may be taken every cycle.
// Output: done is high for exactly one cycle with result valid; take it then.
// Configuration: cfg_we with cfg_wdata writes the fallback threshold; write
// only while no item is in flight.
// Path: the accepting edge registers the item, which then passes three
// normalizers in series: given axis, side axis, and the third axis of W
// mode. Each normalizer has five scaling stages, 32 square root stages,
// 31 + FRAC_BITS divider stages and one output stage; done is registered.
// Throughput: one item per cycle, sustained.
// Reset clears all valid bits and loads the default threshold; items in
// flight are dropped. There is no output stall.
module orthonormal_basis_builder import onb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  request_t            request,
  output logic                done,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata
);

  localparam int L        = NORM_PRE + SQRT_STEPS + MAG_W + FRAC_BITS + 1;
  localparam int CMD_LEN  = 3 * L + 4;
  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    vec32_t vec;
    logic   zero;
  } axis_t;

  function automatic logic [63:0] sext(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [31:0] round_sat(input logic [63:0] raw);
    logic signed [64:0] sum;
    logic signed [64:0] sh;
    sum = $signed({raw[63], raw}) + HALF;
    sh  = sum >>> FRAC_BITS;
    if (sh > 65'sd2147483647) return 32'h7FFF_FFFF;
    if (sh < -65'sd2147483648) return 32'h8000_0000;
    return sh[31:0];
  endfunction

  logic [THRESH_W-1:0] thresh;
  logic                r0_v;
  request_t            r0;
  logic [3:0]          cp [0:CMD_LEN-1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
      r0_v   <= 1'b0;
    end else begin
      if (cfg_we) thresh <= cfg_wdata;
      r0_v <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) r0 <= request;
    cp[0] <= r0.cmd;
    for (int j = 1; j < CMD_LEN; j++) cp[j] <= cp[j-1];
  end

  // pair cross product, operands swapped for the reversed pair modes
  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic signed [63:0] pp [6];
  vec64_t             pr_pipe [0:L-1];
  logic               pair_swap;

  assign pair_swap = r0.cmd inside {MODE_VU, MODE_UW, MODE_WV};

  always_comb begin
    pa[0] = pair_swap ? r0.second_x : r0.first_x;
    pa[1] = pair_swap ? r0.second_y : r0.first_y;
    pa[2] = pair_swap ? r0.second_z : r0.first_z;
    pb[0] = pair_swap ? r0.first_x : r0.second_x;
    pb[1] = pair_swap ? r0.first_y : r0.second_y;
    pb[2] = pair_swap ? r0.first_z : r0.second_z;
  end

  always_ff @(posedge clk) begin
    pp[0] <= pa[1] * pb[2];
    pp[1] <= pa[2] * pb[1];
    pp[2] <= pa[2] * pb[0];
    pp[3] <= pa[0] * pb[2];
    pp[4] <= pa[0] * pb[1];
    pp[5] <= pa[1] * pb[0];
    pr_pipe[0][0] <= pp[0] - pp[1];
    pr_pipe[0][1] <= pp[2] - pp[3];
    pr_pipe[0][2] <= pp[4] - pp[5];
    for (int j = 1; j < L; j++) pr_pipe[j] <= pr_pipe[j-1];
  end

  // given axis
  logic   n1_v;
  vec32_t n1_vec;
  logic   n1_zero;
  vec64_t n1_in;

  assign n1_in[0] = sext(r0.first_x);
  assign n1_in[1] = sext(r0.first_y);
  assign n1_in[2] = sext(r0.first_z);

  onb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_given (
    .clk(clk), .rst(rst), .in_valid(r0_v), .vec(n1_in),
    .out_valid(n1_v), .unit(n1_vec), .zero(n1_zero)
  );

  axis_t a_pipe [0:2*L+3];

  always_ff @(posedge clk) begin
    a_pipe[0] <= '{vec: n1_vec, zero: n1_zero};
    for (int j = 1; j < 2 * L + 4; j++) a_pipe[j] <= a_pipe[j-1];
  end

  // side axis: squared length of a x X, then pick X or Y; pair modes take the pair cross product
  logic        s1_v;
  logic [63:0] sy2;
  logic [63:0] sz2;
  logic [31:0] my;
  logic [31:0] mz;
  logic [63:0] side_len;
  logic        use_y;
  vec64_t      side_vec;
  logic        x2_v;
  vec64_t      x2;
  vec32_t      a1;

  assign my = n1_vec[1][31] ? 32'd0 - n1_vec[1] : n1_vec[1];
  assign mz = n1_vec[2][31] ? 32'd0 - n1_vec[2] : n1_vec[2];
  assign a1 = a_pipe[0].vec;
  assign side_len = sy2 + sz2;
  assign use_y = (side_len >> FRAC_BITS) < 64'(thresh);

  always_comb begin
    if (use_y) begin
      side_vec[0] = 64'd0 - sext(a1[2]);
      side_vec[1] = 64'd0;
      side_vec[2] = sext(a1[0]);
    end else begin
      side_vec[0] = 64'd0;
      side_vec[1] = sext(a1[2]);
      side_vec[2] = 64'd0 - sext(a1[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      x2_v <= 1'b0;
    end else begin
      s1_v <= n1_v;
      x2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    sy2 <= my * my;
    sz2 <= mz * mz;
    x2  <= (cp[L] inside {[MODE_UV:MODE_WV]}) ? pr_pipe[L-1] : side_vec;
  end

  // second axis
  logic   n2_v;
  vec32_t n2_vec;
  logic   n2_zero;

  onb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_second (
    .clk(clk), .rst(rst), .in_valid(x2_v), .vec(x2),
    .out_valid(n2_v), .unit(n2_vec), .zero(n2_zero)
  );

  axis_t s_pipe [0:L+1];

  always_ff @(posedge clk) begin
    s_pipe[0] <= '{vec: n2_vec, zero: n2_zero};
    for (int j = 1; j < L + 2; j++) s_pipe[j] <= s_pipe[j-1];
  end

  // third axis cross product; second x first for the listed modes
  logic signed [31:0] ta [3];
  logic signed [31:0] tb [3];
  logic signed [63:0] tp [6];
  logic               tp_v;
  logic               cr_v;
  vec64_t             cr;
  logic               third_swap;
  vec32_t             a2;
  logic [31:0]        rnd_pipe [0:L-1][3];

  assign a2 = a_pipe[L+1].vec;
  assign third_swap = cp[2*L+1] inside {MODE_V, MODE_UV, MODE_WU, MODE_VW};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ta[i] = third_swap ? n2_vec[i] : a2[i];
      tb[i] = third_swap ? a2[i] : n2_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tp_v <= 1'b0;
      cr_v <= 1'b0;
    end else begin
      tp_v <= n2_v;
      cr_v <= tp_v;
    end
  end

  always_ff @(posedge clk) begin
    tp[0] <= ta[1] * tb[2];
    tp[1] <= ta[2] * tb[1];
    tp[2] <= ta[2] * tb[0];
    tp[3] <= ta[0] * tb[2];
    tp[4] <= ta[0] * tb[1];
    tp[5] <= ta[1] * tb[0];
    cr[0] <= tp[0] - tp[1];
    cr[1] <= tp[2] - tp[3];
    cr[2] <= tp[4] - tp[5];
    for (int i = 0; i < 3; i++) rnd_pipe[0][i] <= round_sat(cr[i]);
    for (int j = 1; j < L; j++) rnd_pipe[j] <= rnd_pipe[j-1];
  end

  // third axis normalized, used by W mode only
  logic   n3_v;
  vec32_t n3_vec;
  logic   n3_zero;

  onb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_third (
    .clk(clk), .rst(rst), .in_valid(cr_v), .vec(cr),
    .out_valid(n3_v), .unit(n3_vec), .zero(n3_zero)
  );

  // frame assembly
  vec32_t  fa;
  vec32_t  fs;
  vec32_t  ft;
  vec32_t  fu;
  vec32_t  fv;
  vec32_t  fw;
  logic    fdeg;
  result_t res_next;

  assign fa = a_pipe[2*L+3].vec;
  assign fs = s_pipe[L+1].vec;

  always_comb begin
    for (int i = 0; i < 3; i++) ft[i] = rnd_pipe[L-1][i];
    fu   = '0;
    fv   = '0;
    fw   = '0;
    fdeg = a_pipe[2*L+3].zero | s_pipe[L+1].zero;
    case (cp[3*L+3])
      MODE_U:  begin fu = fa; fv = fs; fw = ft; end
      MODE_V:  begin fv = fa; fu = fs; fw = ft; end
      MODE_W:  begin
        fw = fa; fu = fs; fv = n3_vec;
        fdeg = fdeg | n3_zero;
      end
      MODE_UV: begin fu = fa; fw = fs; fv = ft; end
      MODE_VU: begin fv = fa; fw = fs; fu = ft; end
      MODE_UW: begin fu = fa; fv = fs; fw = ft; end
      MODE_WU: begin fw = fa; fv = fs; fu = ft; end
      MODE_VW: begin fv = fa; fu = fs; fw = ft; end
      MODE_WV: begin fw = fa; fu = fs; fv = ft; end
      default: fdeg = 1'b1;
    endcase
    res_next.basis_u_x  = fu[0];
    res_next.basis_u_y  = fu[1];
    res_next.basis_u_z  = fu[2];
    res_next.basis_v_x  = fv[0];
    res_next.basis_v_y  = fv[1];
    res_next.basis_v_z  = fv[2];
    res_next.basis_w_x  = fw[0];
    res_next.basis_w_y  = fw[1];
    res_next.basis_w_z  = fw[2];
    res_next.degenerate = fdeg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= n3_v;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

// ===== tb/sv/orthonormal_basis_builder_checker.sv =====
// Checker: predicts each frame from the accepted items and compares with the results.
`timescale 1ns / 1ps
module orthonormal_basis_builder_checker import onb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  request_t            request,
  input  logic                done,
  input  result_t             result,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata,
  output int                  frames_pending,
  output int                  errors
);

  localparam int FB = 30;

  typedef longint v3_t [3];

  logic [THRESH_W-1:0] fallback_thr;
  result_t             frame_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // floor(mag * 2^FB / s); quotients past bit 39 clip to 2^40
  function automatic logic [63:0] frac_quot(logic [63:0] mag, logic [63:0] s);
    logic [63:0] rem, q;
    bit big;
    rem = 0;
    q = 0;
    big = 0;
    for (int b = 31 + FB - 1; b >= 0; b--) begin
      rem = (rem << 1) | ((b >= FB) ? ((mag >> (b - FB)) & 64'd1) : 64'd0);
      if (rem >= s) begin
        rem = rem - s;
        if (b < 40) q = q | (64'd1 << b);
        else big = 1;
      end
    end
    return big ? (64'd1 << 40) : q;
  endfunction

  function automatic v3_t unit_vec(v3_t a, inout bit deg);
    logic [63:0] mag[3];
    logic [63:0] m, len2, s;
    longint q;
    v3_t r;
    m = 0;
    len2 = 0;
    r = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      mag[i] = (a[i] < 0) ? -a[i] : a[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      deg = 1;
      return r;
    end
    while (m >= (64'd1 << 31)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) len2 = len2 + mag[i] * mag[i];
    s = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = frac_quot(mag[i], s);
      r[i] = clip32(a[i] < 0 ? -q : q);
    end
    return r;
  endfunction

  function automatic v3_t cross_full(v3_t a, v3_t b);
    v3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // round half up at FB and saturate
  function automatic v3_t cross_round(v3_t a, v3_t b);
    v3_t r;
    r = cross_full(a, b);
    for (int i = 0; i < 3; i++) r[i] = clip32((r[i] + (64'sd1 <<< (FB - 1))) >>> FB);
    return r;
  endfunction

  // a x X, or a x Y when a x X is too short
  function automatic v3_t side_axis(v3_t a, logic [THRESH_W-1:0] thr, inout bit deg);
    logic [63:0] my, mz;
    v3_t c;
    my = (a[1] < 0) ? -a[1] : a[1];
    mz = (a[2] < 0) ? -a[2] : a[2];
    c = '{0, a[2], -a[1]};
    if (((my * my + mz * mz) >> FB) < {33'd0, thr}) c = '{-a[2], 0, a[0]};
    return unit_vec(c, deg);
  endfunction

  function automatic result_t build_frame(request_t r, logic [THRESH_W-1:0] thr);
    v3_t p, q, u, v, w;
    bit deg;
    result_t f;
    p = '{longint'(r.first_x), longint'(r.first_y), longint'(r.first_z)};
    q = '{longint'(r.second_x), longint'(r.second_y), longint'(r.second_z)};
    u = '{0, 0, 0};
    v = u;
    w = u;
    deg = 0;
    case (r.cmd)
      MODE_U: begin
        u = unit_vec(p, deg); v = side_axis(u, thr, deg); w = cross_round(u, v);
      end
      MODE_V: begin
        v = unit_vec(p, deg); u = side_axis(v, thr, deg); w = cross_round(u, v);
      end
      MODE_W: begin
        w = unit_vec(p, deg); u = side_axis(w, thr, deg);
        v = unit_vec(cross_full(w, u), deg);
      end
      MODE_UV: begin
        u = unit_vec(p, deg); w = unit_vec(cross_full(p, q), deg); v = cross_round(w, u);
      end
      MODE_VU: begin
        v = unit_vec(p, deg); w = unit_vec(cross_full(q, p), deg); u = cross_round(v, w);
      end
      MODE_UW: begin
        u = unit_vec(p, deg); v = unit_vec(cross_full(q, p), deg); w = cross_round(u, v);
      end
      MODE_WU: begin
        w = unit_vec(p, deg); v = unit_vec(cross_full(p, q), deg); u = cross_round(v, w);
      end
      MODE_VW: begin
        v = unit_vec(p, deg); u = unit_vec(cross_full(p, q), deg); w = cross_round(u, v);
      end
      MODE_WV: begin
        w = unit_vec(p, deg); u = unit_vec(cross_full(q, p), deg); v = cross_round(w, u);
      end
      default: deg = 1;
    endcase
    f.basis_u_x = u[0][31:0]; f.basis_u_y = u[1][31:0]; f.basis_u_z = u[2][31:0];
    f.basis_v_x = v[0][31:0]; f.basis_v_y = v[1][31:0]; f.basis_v_z = v[2][31:0];
    f.basis_w_x = w[0][31:0]; f.basis_w_y = w[1][31:0]; f.basis_w_z = w[2][31:0];
    f.degenerate = deg;
    return f;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;

  assign frames_pending = frame_q.size();

  always @(posedge clk) begin
    result_t want;
    logic [288:0] g, e;
    if (rst) begin
      fallback_thr <= THRESH_RESET;
      frame_q.delete();
    end else begin
      if (cfg_we) fallback_thr <= cfg_wdata;
      if (start && !busy) frame_q.push_back(build_frame(request, fallback_thr));
      if (done) begin
        if (frame_q.size() == 0) begin
          report("unexpected result", 32'd0, 32'd0);
        end else begin
          want = frame_q.pop_front();
          g = result;
          e = want;
          for (int i = 0; i < 9; i++)
            if (g[288 - 32*i -: 32] !== e[288 - 32*i -: 32])
              report($sformatf("axis field %0d", i), g[288 - 32*i -: 32],
                     e[288 - 32*i -: 32]);
          if (g[0] !== e[0]) report("degenerate", {31'd0, g[0]}, {31'd0, e[0]});
        end
      end
    end
  end

endmodule

// ===== tb/sv/orthonormal_basis_builder_tb.sv =====
// Top of the testbench: clock, reset, item and threshold stimulus, verdict.
`timescale 1ns / 1ps
module orthonormal_basis_builder_tb import onb_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_TAIL  = 320;
  localparam logic [31:0] ONE = 32'h4000_0000;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  request_t            request;
  logic                done;
  result_t             result;
  logic                cfg_we;
  logic [THRESH_W-1:0] cfg_wdata;
  int                  frames_pending;
  int                  errors;
  int                  cycles;
  bit                  idling;

  orthonormal_basis_builder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  orthonormal_basis_builder_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .frames_pending(frames_pending), .errors(errors)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold start high across back-to-back items; drop it only for a gap
  task automatic send(request_t r);
    bit taken;
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    request <= r;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    do @(negedge clk); while (frames_pending != 0);
    @(posedge clk);
  endtask

  task automatic set_threshold(logic [THRESH_W-1:0] v);
    drain();
    repeat (5) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom_range(0, 16) - 8;
      4: return $urandom_range(0, 4095) - 2048;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t rand_item();
    request_t r;
    r.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
    r.first_x = rand_comp(); r.first_y = rand_comp(); r.first_z = rand_comp();
    r.second_x = rand_comp(); r.second_y = rand_comp(); r.second_z = rand_comp();
    case ($urandom_range(0, 9))
      // near the X axis, so the Y fallback decides
      0, 1: begin
        r.first_x = $urandom;
        r.first_y = $urandom_range(0, 65535) - 32768;
        r.first_z = $urandom_range(0, 65535) - 32768;
      end
      // parallel pair gives a zero cross product
      2: begin
        r.second_x = r.first_x; r.second_y = r.first_y; r.second_z = r.first_z;
      end
      3: begin
        r.first_x = 0; r.first_y = 0; r.first_z = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic request_t mk(logic [3:0] c, logic [31:0] px, logic [31:0] py,
                                 logic [31:0] pz, logic [31:0] qx, logic [31:0] qy,
                                 logic [31:0] qz);
    request_t r;
    r.cmd = c;
    r.first_x = px; r.first_y = py; r.first_z = pz;
    r.second_x = qx; r.second_y = qy; r.second_z = qz;
    return r;
  endfunction

  initial begin
    logic [THRESH_W-1:0] thr_list[5];
    rst = 1;
    start = 0;
    request = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    idling = 1;
    thr_list = '{THRESH_RESET, 0, 31'h4000_0000, 31'($urandom_range(0, 1 << 30)), 1};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every mode on the X axis, then extremes and degenerate cases
    idling = 0;
    for (int c = MODE_U; c <= MODE_WV; c++) send(mk(4'(c), ONE, 0, 0, 0, ONE, 0));
    send(mk(MODE_U, 0, 0, 0, 0, 0, 0));
    send(mk(MODE_W, 0, 0, 0, ONE, 0, 0));
    send(mk(MODE_UV, 0, 0, 0, 0, ONE, 0));
    send(mk(MODE_VW, ONE, ONE, 0, ONE, ONE, 0));
    send(mk(MODE_V, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
    send(mk(MODE_WU, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send(mk(MODE_U, 1, 0, 0, 0, 0, 0));
    send(mk(MODE_UW, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
    send(mk(MODE_VU, 32'h8000_0000, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send(mk(4'd9, ONE, ONE, ONE, ONE, ONE, ONE));
    send(mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    idling = 1;

    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(thr_list[ph]);
      idling = (ph != 4);
      for (int n = 0; n < 86; n++) begin
        if (ph == 1 && n == 40) drain();
        send(rand_item());
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/onb_pkg.sv
rtl/onb_norm.sv
rtl/orthonormal_basis_builder.sv
tb/sv/orthonormal_basis_builder_checker.sv
tb/sv/orthonormal_basis_builder_tb.sv
